FILE: sv/socd_last_input_resolver_core_assert.svh
// ----------------------------------------------------------------------------
// SOCD resolver assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOCD_LAST_INPUT_RESOLVER_CORE_ASSERT_SVH
`define SOCD_LAST_INPUT_RESOLVER_CORE_ASSERT_SVH

// same-cycle implication
`define SOCD_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("socd assertion failed");

// next-cycle implication
`define SOCD_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("socd assertion failed");

`endif

FILE: sv/socd_pkg.sv
// ----------------------------------------------------------------------------
// socd_pkg
// Types, codes and constants shared by the SOCD resolver modules.
// ----------------------------------------------------------------------------
package socd_pkg;

  // result actions
  typedef enum logic [1:0] {
    ACT_PASS    = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_MIDI    = 2'd3
  } action_t;

  // input key kinds
  localparam logic [3:0] KIND_W       = 4'd0;
  localparam logic [3:0] KIND_A       = 4'd1;
  localparam logic [3:0] KIND_S       = 4'd2;
  localparam logic [3:0] KIND_D       = 4'd3;
  localparam logic [3:0] KIND_Z       = 4'd4;
  localparam logic [3:0] KIND_X       = 4'd5;
  localparam logic [3:0] KIND_ENC_CW  = 4'd6;
  localparam logic [3:0] KIND_ENC_CCW = 4'd7;

  // resolver modes
  localparam logic [2:0] MODE_OFF   = 3'd0;
  localparam logic [2:0] MODE_BOTH  = 3'd1;
  localparam logic [2:0] MODE_HORIZ = 3'd2;
  localparam logic [2:0] MODE_VERT  = 3'd3;
  localparam logic [2:0] MODE_ZX    = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SOCD_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL = 1'b1;

  // MIDI control change constants
  localparam logic [6:0] CC_NUMBER    = 7'd89;
  localparam logic [6:0] CC_VALUE_CW  = 7'd1;
  localparam logic [6:0] CC_VALUE_CCW = 7'd127;

  // command queue sizing
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [3:0] kind;
    logic       pressed;
  } in_item_t;

  typedef struct packed {
    action_t    action;
    logic [2:0] key_id;
    logic [3:0] cc_channel;
    logic [6:0] cc_number;
    logic [6:0] cc_value;
    logic       last;
  } out_item_t;

  // one classified event: one or two result beats
  typedef struct packed {
    out_item_t first;
    out_item_t second;
    logic      two;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

FILE: sv/socd_front.sv
// ----------------------------------------------------------------------------
// socd_front
// Accepts key events, tracks held flags and config, builds result commands.
// ----------------------------------------------------------------------------
module socd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [socd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [socd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_push,
  input  socd_pkg::in_item_t                  in_data,
  output logic                                in_full,
  input  socd_pkg::q_stat_t                   q_stat,
  output logic                                q_push,
  output socd_pkg::cmd_t                      q_cmd
);

  // held flag positions
  localparam logic [1:0] FLAG_UP    = 2'd0;
  localparam logic [1:0] FLAG_LEFT  = 2'd1;
  localparam logic [1:0] FLAG_DOWN  = 2'd2;
  localparam logic [1:0] FLAG_RIGHT = 2'd3;

  logic [2:0] mode_r;
  logic [3:0] chan_r;
  logic [3:0] held_r, held_nxt;

  logic       is_enc, resolved;
  logic [1:0] own_idx, opp_idx;
  logic [2:0] key, opp_key;
  logic       other_held;
  socd_pkg::cmd_t cmd;

  assign in_full = q_stat.full;
  assign q_push  = in_push && !q_stat.full;
  assign q_cmd   = cmd;

  // decode which keys the mode resolves
  always_comb begin
    unique case (mode_r)
      socd_pkg::MODE_BOTH:  resolved = (in_data.kind <= socd_pkg::KIND_D);
      socd_pkg::MODE_HORIZ: resolved = (in_data.kind == socd_pkg::KIND_A) ||
                                       (in_data.kind == socd_pkg::KIND_D);
      socd_pkg::MODE_VERT:  resolved = (in_data.kind == socd_pkg::KIND_W) ||
                                       (in_data.kind == socd_pkg::KIND_S);
      socd_pkg::MODE_ZX:    resolved = (in_data.kind == socd_pkg::KIND_Z) ||
                                       (in_data.kind == socd_pkg::KIND_X);
      default:              resolved = 1'b0;
    endcase
  end

  // own flag, opposite flag and opposite key
  always_comb begin
    unique case (in_data.kind)
      socd_pkg::KIND_W: begin own_idx = FLAG_UP;    opp_idx = FLAG_DOWN;  end
      socd_pkg::KIND_A: begin own_idx = FLAG_LEFT;  opp_idx = FLAG_RIGHT; end
      socd_pkg::KIND_S: begin own_idx = FLAG_DOWN;  opp_idx = FLAG_UP;    end
      socd_pkg::KIND_D: begin own_idx = FLAG_RIGHT; opp_idx = FLAG_LEFT;  end
      socd_pkg::KIND_Z: begin own_idx = FLAG_UP;    opp_idx = FLAG_DOWN;  end
      default:          begin own_idx = FLAG_DOWN;  opp_idx = FLAG_UP;    end
    endcase
    unique case (in_data.kind)
      socd_pkg::KIND_W: opp_key = socd_pkg::KIND_S[2:0];
      socd_pkg::KIND_A: opp_key = socd_pkg::KIND_D[2:0];
      socd_pkg::KIND_S: opp_key = socd_pkg::KIND_W[2:0];
      socd_pkg::KIND_D: opp_key = socd_pkg::KIND_A[2:0];
      socd_pkg::KIND_Z: opp_key = socd_pkg::KIND_X[2:0];
      default:          opp_key = socd_pkg::KIND_Z[2:0];
    endcase
  end

  assign key        = in_data.kind[2:0];
  assign other_held = held_r[opp_idx];
  assign is_enc     = (mode_r <= socd_pkg::MODE_ZX) &&
                      ((in_data.kind == socd_pkg::KIND_ENC_CW) ||
                       (in_data.kind == socd_pkg::KIND_ENC_CCW));

  // build the command and the next held flags
  always_comb begin
    cmd      = '0;
    held_nxt = held_r;
    cmd.first.action  = socd_pkg::ACT_PASS;
    cmd.second.action = socd_pkg::ACT_PASS;
    if (is_enc) begin
      if (in_data.pressed) begin
        cmd.first.action     = socd_pkg::ACT_MIDI;
        cmd.first.cc_channel = chan_r;
        cmd.first.cc_number  = socd_pkg::CC_NUMBER;
        cmd.first.cc_value   = (in_data.kind == socd_pkg::KIND_ENC_CW) ?
                               socd_pkg::CC_VALUE_CW : socd_pkg::CC_VALUE_CCW;
        cmd.second.last      = 1'b1;
        cmd.two              = 1'b1;
      end else begin
        cmd.first.last = 1'b1;
      end
    end else if (resolved) begin
      if (in_data.pressed) begin
        held_nxt[own_idx] = 1'b1;
        if (other_held) begin
          cmd.first.action  = socd_pkg::ACT_RELEASE;
          cmd.first.key_id  = opp_key;
          cmd.second.action = socd_pkg::ACT_PRESS;
          cmd.second.key_id = key;
          cmd.second.last   = 1'b1;
          cmd.two           = 1'b1;
        end else begin
          cmd.first.action = socd_pkg::ACT_PRESS;
          cmd.first.key_id = key;
          cmd.first.last   = 1'b1;
        end
      end else begin
        held_nxt[own_idx] = 1'b0;
        cmd.first.action  = socd_pkg::ACT_RELEASE;
        cmd.first.key_id  = key;
        if (other_held) begin
          cmd.second.action = socd_pkg::ACT_PRESS;
          cmd.second.key_id = opp_key;
          cmd.second.last   = 1'b1;
          cmd.two           = 1'b1;
        end else begin
          cmd.first.last = 1'b1;
        end
      end
    end else begin
      cmd.first.last = 1'b1;
    end
  end

  // config registers and held flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= socd_pkg::MODE_OFF;
      chan_r <= '0;
      held_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          socd_pkg::CFG_SOCD_MODE:    mode_r <= cfg_wdata[2:0];
          socd_pkg::CFG_MIDI_CHANNEL: chan_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (q_push) begin
        held_r <= held_nxt;
      end
    end
  end

endmodule

FILE: sv/socd_cmdq.sv
// ----------------------------------------------------------------------------
// socd_cmdq
// Short register queue of classified commands between front and back.
// ----------------------------------------------------------------------------
`include "socd_last_input_resolver_core_assert.svh"

module socd_cmdq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  socd_pkg::cmd_t     push_data,
  input  logic               pop,
  output socd_pkg::cmd_t     pop_data,
  output socd_pkg::q_stat_t  stat
);

  localparam logic [socd_pkg::QPTR_W-1:0] PTR_LAST =
    socd_pkg::QPTR_W'(socd_pkg::QDEPTH - 1);
  localparam logic [socd_pkg::QCNT_W-1:0] CNT_FULL =
    socd_pkg::QCNT_W'(socd_pkg::QDEPTH);

  socd_pkg::cmd_t                mem_r [socd_pkg::QDEPTH];
  logic [socd_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [socd_pkg::QCNT_W-1:0]   cnt_r;
  logic                          do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_FULL);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `SOCD_ASSERT_IMP(a_cnt_in_range, 1'b1, cnt_r <= CNT_FULL)
  `SOCD_ASSERT_NXT(a_push_fills, do_push && !do_pop, cnt_r != '0)

endmodule

FILE: sv/socd_back.sv
// ----------------------------------------------------------------------------
// socd_back
// Drains commands into result beats through an output register.
// ----------------------------------------------------------------------------
`include "socd_last_input_resolver_core_assert.svh"

module socd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  socd_pkg::cmd_t       q_cmd,
  input  socd_pkg::q_stat_t    q_stat,
  output logic                 q_pop,
  input  logic                 out_pop,
  output logic                 out_empty,
  output socd_pkg::out_item_t  out_data
);

  logic                 out_valid_r, out_valid_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  socd_pkg::out_item_t  out_data_r, out_data_nxt;
  socd_pkg::out_item_t  pend_data_r, pend_data_nxt;
  logic                 slot_free;

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_pop;
  assign q_pop     = slot_free && !pend_valid_r && !q_stat.empty;

  // load the output slot: pending second beat first, then the queue head
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    pend_valid_nxt = pend_valid_r;
    pend_data_nxt  = pend_data_r;
    if (slot_free) begin
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = pend_data_r;
        pend_valid_nxt = 1'b0;
      end else if (!q_stat.empty) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = q_cmd.first;
        pend_valid_nxt = q_cmd.two;
        pend_data_nxt  = q_cmd.second;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // beat payloads
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    pend_data_r <= pend_data_nxt;
  end

  `SOCD_ASSERT_IMP(a_pend_needs_out, pend_valid_r, out_valid_r)
  `SOCD_ASSERT_NXT(a_second_follows, out_valid_r && out_pop && !out_data_r.last, out_valid_r)
  `SOCD_ASSERT_IMP(a_no_pop_with_pend, pend_valid_r, !q_pop)

endmodule

FILE: sv/socd_last_input_resolver_core.sv
// An accepted event is written to the command queue; its result beat then reaches the
// outputs through the output register. One event per cycle is taken when each gives
// one beat; the output register drains one beat per cycle while out_pop takes each beat.
// A two-entry command queue lets events be taken while results wait.
// Reset (rst_n low, synchronous) clears held flags, config, queue and output.
// ----------------------------------------------------------------------------
// socd_last_input_resolver_core
// SOCD cleaner with last-input priority and encoder MIDI control change.
// ----------------------------------------------------------------------------
module socd_last_input_resolver_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [socd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [socd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_push,
  input  socd_pkg::in_item_t               in_data,
  output logic                             in_full,
  input  logic                             out_pop,
  output logic                             out_empty,
  output socd_pkg::out_item_t              out_data
);

  logic               q_push, q_pop;
  socd_pkg::cmd_t     q_wr_cmd, q_rd_cmd;
  socd_pkg::q_stat_t  q_stat;

  // classify events
  socd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (q_wr_cmd)
  );

  // command queue
  socd_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_cmd),
    .pop       (q_pop),
    .pop_data  (q_rd_cmd),
    .stat      (q_stat)
  );

  // emit result beats
  socd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (q_rd_cmd),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
